/* src/smeu_pkg.sv */
package smeu_pkg;

  localparam int DATA_DEPTH = 16;
  localparam int CALL_DEPTH = 16;
  localparam int ADDR_BITS  = 16;
  localparam int DP_BITS    = $clog2(DATA_DEPTH + 1);
  localparam int DI_BITS    = $clog2(DATA_DEPTH);
  localparam int RP_BITS    = $clog2(CALL_DEPTH + 1);
  localparam int RI_BITS    = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;

  typedef enum logic [4:0] {
    CMD_POP = 5'd0, CMD_PUSH = 5'd1, CMD_ADD = 5'd2, CMD_SUB = 5'd3,
    CMD_MUL = 5'd4, CMD_DIV = 5'd5, CMD_EQ = 5'd6, CMD_NE = 5'd7,
    CMD_GT = 5'd8, CMD_LT = 5'd9, CMD_GE = 5'd10, CMD_LE = 5'd11,
    CMD_PRINT = 5'd12, CMD_DUP = 5'd13, CMD_JUMP = 5'd14, CMD_CALL = 5'd15,
    CMD_RET = 5'd16, CMD_IF = 5'd17, CMD_HALT = 5'd18
  } cmd_t;

  typedef enum logic [2:0] {
    FLT_NONE = 3'd0, FLT_UNDER = 3'd1, FLT_OVER = 3'd2,
    FLT_DIVZ = 3'd3, FLT_CALL = 3'd4
  } fault_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture request, start operand reads
    logic exec;     // commit instruction from read operands
    logic div_go;   // start the divider
    logic div_fin;  // commit the divide result
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic is_div;   // request needs the divider
    logic div_done;
  } stat_t;

endpackage

/* src/smeu_datapath.sv */
module smeu_datapath
  import smeu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_t                ctrl,
  output stat_t                stat,
  input  logic [4:0]           command,
  input  logic [31:0]          operand,
  output logic [15:0]          next_address,
  output logic [31:0]          top_value,
  output logic [4:0]           stack_depth,
  output logic                 print_valid,
  output logic                 halted,
  output logic [2:0]           fault
);

  logic [31:0]          dmem [DATA_DEPTH];
  logic [ADDR_BITS-1:0] rmem [CALL_DEPTH];
  logic [DP_BITS-1:0]   dp;
  logic [RP_BITS-1:0]   rp;
  logic [ADDR_BITS-1:0] pc;
  logic                 hf;
  logic [4:0]           cmd;
  logic [31:0]          opnd;
  logic [31:0]          rd_a;     // entry below top
  logic [31:0]          rd_b;     // top
  logic [ADDR_BITS-1:0] rd_r;     // return top
  logic [31:0]          top;      // shadow of stack top
  logic [ADDR_BITS-1:0] pc1, pc2, tgt;

  // divider state
  logic [31:0] quo, rem, dvs;
  logic [5:0]  dcnt;
  logic        qneg;
  logic        dbusy;

  assign pc1 = pc + ADDR_BITS'(1);
  assign pc2 = pc + ADDR_BITS'(2);
  assign tgt = opnd[ADDR_BITS-1:0];
  assign stat.is_div = (cmd == CMD_DIV) && !hf && (dp >= DP_BITS'(2));
  assign stat.div_done = dbusy && (dcnt == 6'd0);

  logic [DI_BITS-1:0] ia, ib;
  assign ib = DI_BITS'(dp - DP_BITS'(1));
  assign ia = DI_BITS'(dp - DP_BITS'(2));

  // capture request and read stacks
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd  <= command;
      opnd <= operand;
    end
    rd_a <= dmem[ia];
    rd_b <= dmem[ib];
    rd_r <= rmem[RI_BITS'(rp - RP_BITS'(1))];
  end

  // execute
  logic [31:0] alu;
  logic        lt_s;
  always_comb begin
    lt_s = $signed(rd_a) < $signed(rd_b);
    case (cmd)
      CMD_ADD: alu = rd_a + rd_b;
      CMD_SUB: alu = rd_a - rd_b;
      CMD_MUL: alu = rd_a * rd_b;
      CMD_EQ:  alu = {31'd0, rd_a == rd_b};
      CMD_NE:  alu = {31'd0, rd_a != rd_b};
      CMD_GT:  alu = {31'd0, !lt_s && rd_a != rd_b};
      CMD_LT:  alu = {31'd0, lt_s};
      CMD_GE:  alu = {31'd0, !lt_s};
      default: alu = {31'd0, lt_s || rd_a == rd_b};
    endcase
  end

  // fault code and new stack top for a non-divide step
  fault_t      fault_next;
  logic [31:0] top_next;
  always_comb begin
    fault_next = FLT_NONE;
    top_next   = rd_b;
    if (!hf) begin
      unique case (cmd) inside
        CMD_POP: if (dp == '0) fault_next = FLT_UNDER;
          else top_next = rd_a;
        CMD_PUSH: if (dp >= DP_BITS'(DATA_DEPTH)) fault_next = FLT_OVER;
          else top_next = opnd;
        [CMD_ADD:CMD_LE]: if (dp < DP_BITS'(2)) fault_next = FLT_UNDER;
          else top_next = alu;
        CMD_PRINT: if (dp == '0) fault_next = FLT_UNDER;
        CMD_DUP: if (dp == '0) fault_next = FLT_UNDER;
          else if (dp >= DP_BITS'(DATA_DEPTH)) fault_next = FLT_OVER;
        CMD_CALL: if (rp >= RP_BITS'(CALL_DEPTH)) fault_next = FLT_CALL;
        CMD_IF: if (dp == '0) fault_next = FLT_UNDER;
          else top_next = rd_a;
        default: ;
      endcase
    end
  end

  logic [31:0] ua, ub;
  logic [32:0] trial;
  assign ua = rd_a[31] ? -rd_a : rd_a;
  assign ub = rd_b[31] ? -rd_b : rd_b;
  assign trial = {rem[31:0], quo[31]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      dp <= '0; rp <= '0; pc <= '0; hf <= 1'b0; dbusy <= 1'b0;
      print_valid <= 1'b0; fault <= FLT_NONE;
    end else begin
      // run the divider for its full count, a zero divisor included
      if (ctrl.div_go) begin
        quo <= ua; rem <= '0; dvs <= ub; dcnt <= 6'd32;
        qneg <= rd_a[31] ^ rd_b[31]; dbusy <= 1'b1;
      end else if (dbusy && dcnt != 6'd0) begin
        dcnt <= dcnt - 6'd1;
        if (!trial[32]) begin
          rem <= trial[31:0]; quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]}; quo <= {quo[30:0], 1'b0};
        end
      end
      if (ctrl.div_fin) begin
        dbusy <= 1'b0;
        if (rd_b == 32'd0) begin
          dmem[ia] <= 32'd0; top <= 32'd0; fault <= FLT_DIVZ;
        end else begin
          dmem[ia] <= qneg ? -quo : quo; top <= qneg ? -quo : quo;
          fault <= FLT_NONE;
        end
        dp <= dp - DP_BITS'(1); pc <= pc1; print_valid <= 1'b0;
      end
      if (ctrl.exec) begin
        print_valid <= !hf && (cmd == CMD_PRINT) && (dp != '0);
        fault <= fault_next;
        top <= top_next;
        if (!hf) begin
          unique case (cmd) inside
            CMD_POP: if (dp != '0) begin dp <= dp - DP_BITS'(1); pc <= pc1; end
            CMD_PUSH: if (dp < DP_BITS'(DATA_DEPTH)) begin
                dmem[DI_BITS'(dp)] <= opnd; dp <= dp + DP_BITS'(1);
                pc <= pc2;
              end
            [CMD_ADD:CMD_LE]: if (dp >= DP_BITS'(2)) begin
                dmem[ia] <= alu;
                dp <= dp - DP_BITS'(1); pc <= pc1;
              end
            CMD_PRINT: if (dp != '0) pc <= pc1;
            CMD_DUP: if (dp != '0 && dp < DP_BITS'(DATA_DEPTH)) begin
                dmem[DI_BITS'(dp)] <= rd_b; dp <= dp + DP_BITS'(1); pc <= pc1;
              end
            CMD_JUMP: pc <= tgt;
            CMD_CALL: if (rp < RP_BITS'(CALL_DEPTH)) begin
                rmem[RI_BITS'(rp)] <= pc2; rp <= rp + RP_BITS'(1); pc <= tgt;
              end
            CMD_RET: if (rp != '0) begin rp <= rp - RP_BITS'(1); pc <= rd_r; end
              else pc <= pc1;
            CMD_IF: if (dp != '0) begin
                dp <= dp - DP_BITS'(1);
                pc <= (rd_b == 32'd0) ? tgt : pc2;
              end
            CMD_HALT: begin hf <= 1'b1; pc <= pc1; end
            default: pc <= pc1;
          endcase
        end
      end
    end
  end

  assign next_address = 16'(pc);
  assign top_value    = (dp == '0) ? 32'd0 : top;
  assign stack_depth  = 5'(dp);
  assign halted       = hf;

endmodule

/* src/smeu_ctrl.sv */
module smeu_ctrl
  import smeu_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output ctrl_t ctrl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // sequence: capture, read stacks, execute or divide, present result
  always_comb begin
    state_next = state;
    ctrl = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin ctrl.load = 1'b1; state_next = ST_READ; end
      end
      ST_READ: state_next = ST_EXEC;
      ST_EXEC: begin
        if (stat.is_div) begin ctrl.div_go = 1'b1; state_next = ST_DIV; end
        else begin ctrl.exec = 1'b1; state_next = ST_OUT; end
      end
      ST_DIV: begin
        if (stat.div_done) begin ctrl.div_fin = 1'b1; state_next = ST_OUT; end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        in_ready = out_ready;
        if (out_ready) begin
          if (in_valid) begin ctrl.load = 1'b1; state_next = ST_READ; end
          else state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* src/stack_machine_execute_unit.sv */
// Each request is captured, its stack operands read, then executed; div runs
// the 32-step divider after the execute state. One request at a time: the next
// request is taken in the cycle the result is taken.
// Reset (rst, synchronous): stacks empty, pc 0, halt flag clear.
module stack_machine_execute_unit
  import smeu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // command[4:0], operand[36:5], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  // next_address[15:0], top_value[47:16], stack_depth[52:48],
  // print_valid[53], halted[54], fault[57:55], zero fill
  output logic [63:0] m_tdata
);

  ctrl_t ctrl;
  stat_t stat;
  logic [15:0] next_address;
  logic [31:0] top_value;
  logic [4:0]  stack_depth;
  logic        print_valid, halted;
  logic [2:0]  fault;

  smeu_ctrl u_ctrl (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready), .stat, .ctrl
  );

  smeu_datapath u_dp (
    .clk, .rst, .ctrl, .stat,
    .command(s_tdata[4:0]), .operand(s_tdata[36:5]),
    .next_address, .top_value, .stack_depth, .print_valid, .halted, .fault
  );

  assign m_tdata = {6'd0, fault, halted, print_valid, stack_depth,
                    top_value, next_address};

  // one request in flight: no accept while a result waits unless it leaves
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("request accepted over pending result");

  // depth never exceeds the stack size
  a_depth: assert property (@(posedge clk) disable iff (rst)
    stack_depth <= 5'(DATA_DEPTH))
    else $error("data stack depth out of range");

  // once halted, stays halted
  a_halt: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halt flag cleared");

endmodule

/* tb/sv/tb_top.sv */
module tb_top
  import smeu_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // command[4:0], operand[36:5], zero fill
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // next_address[15:0], top_value[47:16], stack_depth[52:48],
  // print_valid[53], halted[54], fault[57:55], zero fill
  logic [63:0] m_tdata;

  typedef struct packed {
    logic [2:0]  fault;
    logic        halted;
    logic        print_valid;
    logic [4:0]  stack_depth;
    logic [31:0] top_value;
    logic [15:0] next_address;
  } step_result_t;

  stack_machine_execute_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // machine state mirror
  logic [31:0] data_mem [DATA_DEPTH];
  logic [15:0] ret_mem [CALL_DEPTH];
  int unsigned dsp, rsp;
  logic [15:0] pc;
  logic        halt_q;
  step_result_t expected_q[$];
  int mismatches = 0;
  int cycle_count = 0;
  int hold_cycles = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int stall_pct;

  function automatic logic [31:0] trunc_div(logic [31:0] a, logic [31:0] b);
    logic [31:0] ua, ub, q;
    ua = a[31] ? -a : a;
    ub = b[31] ? -b : b;
    q = ua / ub;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  // advance the mirror by one instruction and queue its result
  task automatic execute_model(logic [4:0] cmd, logic [31:0] opnd);
    step_result_t r;
    logic [31:0] a, b, v;
    logic [2:0]  flt;
    logic        pv;
    flt = FLT_NONE;
    pv = 1'b0;
    if (!halt_q) begin
      case (cmd)
        CMD_POP:
          if (dsp < 1) flt = FLT_UNDER;
          else begin dsp--; pc = pc + 16'd1; end
        CMD_PUSH:
          if (dsp >= DATA_DEPTH) flt = FLT_OVER;
          else begin data_mem[dsp] = opnd; dsp++; pc = pc + 16'd2; end
        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_EQ, CMD_NE,
        CMD_GT, CMD_LT, CMD_GE, CMD_LE:
          if (dsp < 2) flt = FLT_UNDER;
          else begin
            a = data_mem[dsp-2];
            b = data_mem[dsp-1];
            case (cmd)
              CMD_ADD: v = a + b;
              CMD_SUB: v = a - b;
              CMD_MUL: v = a * b;
              CMD_DIV:
                if (b == 0) begin v = 0; flt = FLT_DIVZ; end
                else v = trunc_div(a, b);
              CMD_EQ: v = {31'd0, a == b};
              CMD_NE: v = {31'd0, a != b};
              CMD_GT: v = {31'd0, $signed(a) > $signed(b)};
              CMD_LT: v = {31'd0, $signed(a) < $signed(b)};
              CMD_GE: v = {31'd0, $signed(a) >= $signed(b)};
              default: v = {31'd0, $signed(a) <= $signed(b)};
            endcase
            data_mem[dsp-2] = v;
            dsp--;
            pc = pc + 16'd1;
          end
        CMD_PRINT:
          if (dsp < 1) flt = FLT_UNDER;
          else begin pv = 1'b1; pc = pc + 16'd1; end
        CMD_DUP:
          if (dsp < 1) flt = FLT_UNDER;
          else if (dsp >= DATA_DEPTH) flt = FLT_OVER;
          else begin data_mem[dsp] = data_mem[dsp-1]; dsp++; pc = pc + 16'd1; end
        CMD_JUMP: pc = opnd[15:0];
        CMD_CALL:
          if (rsp >= CALL_DEPTH) flt = FLT_CALL;
          else begin ret_mem[rsp] = pc + 16'd2; rsp++; pc = opnd[15:0]; end
        CMD_RET:
          if (rsp > 0) begin rsp--; pc = ret_mem[rsp]; end
          else pc = pc + 16'd1;
        CMD_IF:
          if (dsp < 1) flt = FLT_UNDER;
          else begin
            v = data_mem[dsp-1];
            dsp--;
            pc = (v == 0) ? opnd[15:0] : pc + 16'd2;
          end
        CMD_HALT: begin halt_q = 1'b1; pc = pc + 16'd1; end
        default: pc = pc + 16'd1;
      endcase
    end
    r.next_address = pc;
    r.top_value = (dsp > 0) ? data_mem[dsp-1] : 32'd0;
    r.stack_depth = dsp[4:0];
    r.print_valid = pv;
    r.halted = halt_q;
    r.fault = flt;
    expected_q.push_back(r);
  endtask

  // send one request, at times after a random gap
  task automatic send_request(logic [4:0] cmd, logic [31:0] opnd);
    if ($urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'd0, opnd, cmd};
    execute_model(cmd, opnd);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic idle_sender();
    s_tvalid <= 1'b0;
  endtask

  task automatic drain();
    idle_sender();
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      4: return $urandom_range(0, 9) - 5;
      default: return $urandom();
    endcase
  endfunction

  task automatic test_directed();
    send_request(CMD_POP, 0);                     // underflow on empty
    send_request(CMD_DUP, 0);
    send_request(CMD_RET, 0);                     // empty call stack
    send_request(CMD_PUSH, 32'h8000_0000);
    send_request(CMD_PUSH, 32'hffff_ffff);
    send_request(CMD_DIV, 0);                     // most negative / -1
    send_request(CMD_PRINT, 0);
    send_request(CMD_PUSH, 32'd7);
    send_request(CMD_PUSH, 32'd0);
    send_request(CMD_DIV, 0);                     // divide by zero
    send_request(CMD_PUSH, -32'sd7);
    send_request(CMD_PUSH, 32'd2);
    send_request(CMD_DIV, 0);                     // truncate toward zero
    send_request(CMD_PUSH, 32'h7fff_ffff);
    send_request(CMD_GT, 0);
    send_request(CMD_IF, 32'h0001_fffe);          // address wrap
    send_request(CMD_CALL, 32'hffff_ffff);
    send_request(CMD_RET, 0);
    send_request(CMD_JUMP, 32'h1234_5678);
    send_request(5'd31, 0);                       // unknown command
    send_request(5'd19, 0);
    drain();
  endtask

  task automatic test_stack_limits();
    for (int i = 0; i < DATA_DEPTH + 2; i++) send_request(CMD_PUSH, rand_value());
    send_request(CMD_DUP, 0);                     // full
    for (int i = 0; i < CALL_DEPTH + 2; i++) send_request(CMD_CALL, $urandom());
    for (int i = 0; i < CALL_DEPTH + 2; i++) send_request(CMD_RET, 0);
    for (int i = 0; i < DATA_DEPTH + 2; i++) send_request(CMD_POP, 0);
    drain();
  endtask

  // hold the receiver off while the sender keeps offering
  task automatic test_backpressure();
    hold_asks++;
    for (int i = 0; i < 20; i++) send_request(CMD_PUSH, $urandom());
    drain();
  endtask

  task automatic test_random();
    logic [4:0] cmd;
    for (int i = 0; i < 480; i++) begin
      if (dsp < 2 && $urandom_range(0, 1)) cmd = CMD_PUSH;
      else if ($urandom_range(0, 40) == 0) cmd = 5'($urandom_range(19, 31));
      else if ($urandom_range(0, 9) == 0) cmd = CMD_DIV;
      else cmd = 5'($urandom_range(0, 17));
      send_request(cmd, (cmd == CMD_PUSH) ? rand_value() : $urandom());
      if (i % 150 == 149) stall_pct = $urandom_range(0, 60);
    end
    drain();
  endtask

  task automatic test_halt();
    send_request(CMD_PUSH, 32'd5);
    send_request(CMD_HALT, 0);
    send_request(CMD_PUSH, 32'd9);
    send_request(CMD_CALL, 32'd3);
    send_request(CMD_HALT, 0);
    send_request(CMD_PRINT, 0);
    drain();
  endtask

  // receiver: stall pattern plus long hold-off
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (hold_asks != hold_seen) begin
      m_tready <= 1'b0;
      hold_cycles <= 200;
      hold_seen <= hold_asks;
    end else if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    step_result_t got, exp_r;
    if (!rst && m_tvalid && m_tready) begin
      got = step_result_t'(m_tdata[57:0]);
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", m_tdata);
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r || m_tdata[63:58] !== 6'd0) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp pc=%h top=%h dp=%0d pv=%b h=%b f=%0d,",
                      " got pc=%h top=%h dp=%0d pv=%b h=%b f=%0d"},
              exp_r.next_address, exp_r.top_value, exp_r.stack_depth,
              exp_r.print_valid, exp_r.halted, exp_r.fault,
              got.next_address, got.top_value, got.stack_depth,
              got.print_valid, got.halted, got.fault);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    stall_pct = 30;
    dsp = 0;
    rsp = 0;
    pc = '0;
    halt_q = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_stack_limits();
    test_backpressure();
    test_random();
    test_halt();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule

/* filelist.f */
src/smeu_pkg.sv
src/smeu_datapath.sv
src/smeu_ctrl.sv
src/stack_machine_execute_unit.sv
tb/sv/tb_top.sv
